@@ rtl/tbt_pkg.sv @@
`timescale 1ns / 1ps

package tbt_pkg;

  // heading resolution, low bits below it are ignored
  localparam int ANGLE_BITS = 16;
  localparam int ANG_DROP = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
  localparam logic [15:0] HEAD_MASK = 16'(16'hFFFF << ANG_DROP);

  localparam int CORDIC_STEPS = 28;
  localparam int TAN_STEPS = 31;
  localparam int DIV_STEPS = 32;
  localparam int CW = 34;
  localparam int NUM_W = 82;
  localparam logic signed [CW-1:0] CORDIC_X0 = CW'(64'd1 << 30);
  localparam logic signed [31:0] SLOPE_MAX = 32'sh7FFF_FFFF;

  // atan(2^-i), 2^32 is one full turn
  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005
  };

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_SAT      = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [31:0] x1;
    logic signed [31:0] z1;
    logic signed [31:0] x2;
    logic signed [31:0] z2;
  } coord_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] a;
  } cordic_t;

  typedef struct packed {
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    coord_t             c;
  } slope_res_t;

  typedef struct packed {
    logic [NUM_W-1:0] un_z;
    logic [NUM_W-1:0] un_x;
    logic [31:0]      den;
    logic             negz;
    logic             negx;
    logic             par;
  } num_t;

  typedef struct packed {
    logic [31:0] qz;
    logic [31:0] qx;
    logic        ovfz;
    logic        ovfx;
    logic        negz;
    logic        negx;
    logic        par;
  } quo_t;

  // one rotation-mode micro-rotation
  function automatic cordic_t cordic_step(cordic_t c, int i);
    cordic_t r;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] at;
    xs = c.x >>> i;
    ys = c.y >>> i;
    at = signed'(CW'(ATAN_TAB[i[4:0]]));
    if (!c.a[CW-1]) begin
      r.x = c.x - ys;
      r.y = c.y + xs;
      r.a = c.a - at;
    end else begin
      r.x = c.x + ys;
      r.y = c.y - xs;
      r.a = c.a + at;
    end
    return r;
  endfunction

endpackage

@@ rtl/tbt_in_if.sv @@
`timescale 1ns / 1ps

interface tbt_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_x;
  logic signed [31:0] first_z;
  logic signed [15:0] first_heading;
  logic signed [31:0] second_x;
  logic signed [31:0] second_z;
  logic signed [15:0] second_heading;

  modport source (
    output valid, first_x, first_z, first_heading, second_x, second_z, second_heading,
    input  ready
  );
  modport sink (
    input  valid, first_x, first_z, first_heading, second_x, second_z, second_heading,
    output ready
  );
endinterface

@@ rtl/tbt_out_if.sv @@
`timescale 1ns / 1ps

interface tbt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cross_x;
  logic signed [31:0] cross_z;
  logic [1:0]         status;

  modport source (
    output valid, cross_x, cross_z, status,
    input  ready
  );
  modport sink (
    input  valid, cross_x, cross_z, status,
    output ready
  );
endinterface

@@ rtl/tbt_slope.sv @@
`timescale 1ns / 1ps

module tbt_slope (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [15:0]         first_heading_i,
  input  logic [15:0]         second_heading_i,
  input  tbt_pkg::coord_t     coord_i,
  output logic                valid_o,
  output tbt_pkg::slope_res_t res_o
);
  import tbt_pkg::*;

  localparam int SlLat = CORDIC_STEPS + TAN_STEPS + 2;

  typedef struct packed {
    logic [30:0] rem;
    logic [30:0] num;
    logic [30:0] den;
    logic [30:0] q;
    logic        ovf;
    logic        yneg;
  } tdiv_t;

  function automatic tdiv_t tan_prep(cordic_t c);
    tdiv_t r;
    logic [CW-1:0] ay;
    logic [CW-1:0] hi;
    ay = c.y[CW-1] ? CW'(-c.y) : CW'(c.y);
    hi = ay >> 15;
    r.yneg = c.y[CW-1];
    r.ovf = c.x[CW-1] || (c.x == '0) || (hi >= CW'(c.x));
    r.rem = hi[30:0];
    r.num = {ay[14:0], 16'b0};
    r.den = c.x[30:0];
    r.q = '0;
    return r;
  endfunction

  function automatic tdiv_t tan_step(tdiv_t s);
    tdiv_t r;
    logic [31:0] r2;
    r = s;
    r2 = {s.rem, s.num[30]};
    if (r2 >= {1'b0, s.den}) begin
      r.rem = 31'(r2 - {1'b0, s.den});
      r.q = {s.q[29:0], 1'b1};
    end else begin
      r.rem = r2[30:0];
      r.q = {s.q[29:0], 1'b0};
    end
    r.num = {s.num[29:0], 1'b0};
    return r;
  endfunction

  // slope is the negated tangent, saturated near the poles
  function automatic logic signed [31:0] tan_slope(tdiv_t s);
    logic sat;
    sat = s.ovf || (s.q == 31'h7FFF_FFFF);
    if (sat) return s.yneg ? SLOPE_MAX : -SLOPE_MAX;
    else return s.yneg ? signed'({1'b0, s.q}) : -signed'({1'b0, s.q});
  endfunction

  logic [15:0]        hd [2];
  cordic_t            c_in [2];
  cordic_t            c_q [2][CORDIC_STEPS];
  tdiv_t              t_q [2][TAN_STEPS+1];
  logic signed [31:0] k_q [2];
  logic               v_q [SlLat];
  coord_t             p_q [SlLat];

  assign hd[0] = first_heading_i & HEAD_MASK;
  assign hd[1] = second_heading_i & HEAD_MASK;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      c_in[l].x = CORDIC_X0;
      c_in[l].y = '0;
      c_in[l].a = {{(CW-31){hd[l][14]}}, hd[l][14:0], 16'b0};
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      if (i == 0) begin : g_first
        always_ff @(posedge clk_i) begin
          if (en_i) c_q[l][i] <= cordic_step(c_in[l], i);
        end
      end else begin : g_next
        always_ff @(posedge clk_i) begin
          if (en_i) c_q[l][i] <= cordic_step(c_q[l][i-1], i);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) t_q[l][0] <= tan_prep(c_q[l][CORDIC_STEPS-1]);
    end

    for (genvar j = 1; j <= TAN_STEPS; j++) begin : g_div
      always_ff @(posedge clk_i) begin
        if (en_i) t_q[l][j] <= tan_step(t_q[l][j-1]);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) k_q[l] <= tan_slope(t_q[l][TAN_STEPS]);
    end
  end

  // valid and coordinates ride alongside
  for (genvar i = 0; i < SlLat; i++) begin : g_side
    if (i == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) v_q[i] <= 1'b0;
        else if (en_i) v_q[i] <= valid_i;
      end
      always_ff @(posedge clk_i) begin
        if (en_i) p_q[i] <= coord_i;
      end
    end else begin : g_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) v_q[i] <= 1'b0;
        else if (en_i) v_q[i] <= v_q[i-1];
      end
      always_ff @(posedge clk_i) begin
        if (en_i) p_q[i] <= p_q[i-1];
      end
    end
  end

  assign valid_o  = v_q[SlLat-1];
  assign res_o.k1 = k_q[0];
  assign res_o.k2 = k_q[1];
  assign res_o.c  = p_q[SlLat-1];

endmodule

@@ rtl/tbt_isect.sv @@
`timescale 1ns / 1ps

module tbt_isect (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  tbt_pkg::slope_res_t res_i,
  output logic                valid_o,
  output tbt_pkg::num_t       num_o
);
  import tbt_pkg::*;

  typedef struct packed {
    logic signed [63:0] p1;
    logic signed [63:0] p2;
    logic signed [63:0] p3;
    logic signed [63:0] p4;
    logic signed [63:0] pk;
    logic signed [32:0] dz;
    logic signed [32:0] dx;
    logic signed [32:0] dd;
    logic               par;
  } sa_t;

  typedef struct packed {
    logic signed [65:0] nz;
    logic signed [64:0] xk;
    logic [62:0]        ml;
    logic [62:0]        mh;
    logic               psign;
    logic signed [32:0] dd;
    logic               par;
  } sb_t;

  typedef struct packed {
    logic signed [95:0] pv;
    logic signed [64:0] xk;
    logic [65:0]        unz;
    logic               negz;
    logic [31:0]        dm;
    logic               dneg;
    logic               par;
  } sc_t;

  typedef struct packed {
    logic signed [96:0] nx;
    logic [65:0]        unz;
    logic               negz;
    logic [31:0]        dm;
    logic               dneg;
    logic               par;
  } sd_t;

  sa_t  sa_d, sa_q;
  sb_t  sb_d, sb_q;
  sc_t  sc_d, sc_q;
  sd_t  sd_d, sd_q;
  num_t ne_d, ne_q;
  logic [3:0] v_q;

  // products
  always_comb begin
    sa_d.p1  = 64'(res_i.k1) * 64'(res_i.c.z1);
    sa_d.p2  = 64'(res_i.k2) * 64'(res_i.c.z2);
    sa_d.p3  = 64'(res_i.c.x2) * 64'(res_i.k1);
    sa_d.p4  = 64'(res_i.c.x1) * 64'(res_i.k2);
    sa_d.pk  = 64'(res_i.k1) * 64'(res_i.k2);
    sa_d.dz  = 33'(res_i.c.z1) - 33'(res_i.c.z2);
    sa_d.dx  = 33'(res_i.c.x2) - 33'(res_i.c.x1);
    sa_d.dd  = 33'(res_i.k1) - 33'(res_i.k2);
    sa_d.par = (res_i.k1 == res_i.k2) ||
               ((res_i.c.x1 == res_i.c.x2) && (res_i.c.z1 == res_i.c.z2));
  end

  // z numerator; split the x numerator term k1*k2*(z1-z2) into two partial products
  always_comb begin
    logic [63:0] pkm;
    logic [32:0] dza;
    pkm = sa_q.pk[63] ? 64'(-sa_q.pk) : 64'(sa_q.pk);
    dza = sa_q.dz[32] ? 33'(-sa_q.dz) : 33'(sa_q.dz);
    sb_d.nz    = 66'(sa_q.p1) - 66'(sa_q.p2) + (66'(sa_q.dx) <<< 16);
    sb_d.xk    = 65'(sa_q.p3) - 65'(sa_q.p4);
    sb_d.ml    = 63'(pkm[30:0]) * 63'(dza[31:0]);
    sb_d.mh    = 63'(pkm[61:31]) * 63'(dza[31:0]);
    sb_d.psign = sa_q.pk[63] ^ sa_q.dz[32];
    sb_d.dd    = sa_q.dd;
    sb_d.par   = sa_q.par;
  end

  always_comb begin
    logic [93:0] pm;
    logic [65:0] anz;
    logic [32:0] ad;
    pm  = {sb_q.mh, 31'b0} + 94'(sb_q.ml);
    anz = sb_q.nz[65] ? 66'(-sb_q.nz) : 66'(sb_q.nz);
    ad  = sb_q.dd[32] ? 33'(-sb_q.dd) : 33'(sb_q.dd);
    sc_d.pv   = sb_q.psign ? -96'(pm) : 96'(pm);
    sc_d.xk   = sb_q.xk;
    sc_d.dm   = ad[31:0];
    sc_d.unz  = anz + 66'(ad[31:1]);
    sc_d.negz = sb_q.nz[65] ^ sb_q.dd[32];
    sc_d.dneg = sb_q.dd[32];
    sc_d.par  = sb_q.par;
  end

  always_comb begin
    sd_d.nx   = 97'(sc_q.pv) + (97'(sc_q.xk) <<< 16);
    sd_d.unz  = sc_q.unz;
    sd_d.negz = sc_q.negz;
    sd_d.dm   = sc_q.dm;
    sd_d.dneg = sc_q.dneg;
    sd_d.par  = sc_q.par;
  end

  // x divisor is d*2^16: round with half of it, then drop the 16 bits
  always_comb begin
    logic [96:0] ax;
    logic [97:0] sum;
    ax  = sd_q.nx[96] ? 97'(-sd_q.nx) : 97'(sd_q.nx);
    sum = 98'(ax) + 98'({sd_q.dm, 15'b0});
    ne_d.un_x = sum[97:16];
    ne_d.un_z = NUM_W'(sd_q.unz);
    ne_d.den  = sd_q.dm;
    ne_d.negz = sd_q.negz;
    ne_d.negx = sd_q.nx[96] ^ sd_q.dneg;
    ne_d.par  = sd_q.par;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sa_q <= sa_d;
      sb_q <= sb_d;
      sc_q <= sc_d;
      sd_q <= sd_d;
      ne_q <= ne_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v_q     <= {v_q[2:0], valid_i};
      valid_o <= v_q[3];
    end
  end

  assign num_o = ne_q;

endmodule

@@ rtl/tbt_div.sv @@
`timescale 1ns / 1ps

module tbt_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  tbt_pkg::num_t num_i,
  output logic          valid_o,
  output tbt_pkg::quo_t quo_o
);
  import tbt_pkg::*;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] lo;
    logic [31:0] q;
    logic        ovf;
  } lane_t;

  typedef struct packed {
    logic [31:0] den;
    logic        negz;
    logic        negx;
    logic        par;
  } side_t;

  // quotient of 2^32 or more flags overflow up front
  function automatic lane_t div_prep(logic [NUM_W-1:0] un, logic [31:0] den);
    lane_t r;
    logic [NUM_W-33:0] hi;
    hi = un[NUM_W-1:32];
    r.ovf = hi >= (NUM_W-32)'(den);
    r.rem = hi[31:0];
    r.lo = un[31:0];
    r.q = '0;
    return r;
  endfunction

  function automatic lane_t div_step(lane_t s, logic [31:0] den);
    lane_t r;
    logic [32:0] r2;
    r = s;
    r2 = {s.rem, s.lo[31]};
    if (r2 >= {1'b0, den}) begin
      r.rem = 32'(r2 - {1'b0, den});
      r.q = {s.q[30:0], 1'b1};
    end else begin
      r.rem = r2[31:0];
      r.q = {s.q[30:0], 1'b0};
    end
    r.lo = {s.lo[30:0], 1'b0};
    return r;
  endfunction

  lane_t z_q [DIV_STEPS+1];
  lane_t x_q [DIV_STEPS+1];
  side_t s_q [DIV_STEPS+1];
  logic  v_q [DIV_STEPS+1];
  side_t s_in;

  assign s_in = '{den: num_i.den, negz: num_i.negz, negx: num_i.negx, par: num_i.par};

  for (genvar i = 0; i <= DIV_STEPS; i++) begin : g_stage
    if (i == 0) begin : g_prep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          z_q[i] <= div_prep(num_i.un_z, num_i.den);
          x_q[i] <= div_prep(num_i.un_x, num_i.den);
          s_q[i] <= s_in;
        end
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) v_q[i] <= 1'b0;
        else if (en_i) v_q[i] <= valid_i;
      end
    end else begin : g_step
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          z_q[i] <= div_step(z_q[i-1], s_q[i-1].den);
          x_q[i] <= div_step(x_q[i-1], s_q[i-1].den);
          s_q[i] <= s_q[i-1];
        end
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) v_q[i] <= 1'b0;
        else if (en_i) v_q[i] <= v_q[i-1];
      end
    end
  end

  assign valid_o    = v_q[DIV_STEPS];
  assign quo_o.qz   = z_q[DIV_STEPS].q;
  assign quo_o.qx   = x_q[DIV_STEPS].q;
  assign quo_o.ovfz = z_q[DIV_STEPS].ovf;
  assign quo_o.ovfx = x_q[DIV_STEPS].ovf;
  assign quo_o.negz = s_q[DIV_STEPS].negz;
  assign quo_o.negx = s_q[DIV_STEPS].negx;
  assign quo_o.par  = s_q[DIV_STEPS].par;

endmodule

@@ rtl/two_bearing_triangulation.sv @@
// path from input beat to result beat: slope, numerator, divide, then output register
// throughput: one beat per cycle; the pipeline holds as a whole only while a result
//   sits in the output register and the sink is not ready
// reset: asynchronous, active low; clears every valid bit, datapath registers are not reset
`timescale 1ns / 1ps

module two_bearing_triangulation (
  input logic    clk_i,
  input logic    rst_ni,
  tbt_in_if.sink    in_i,
  tbt_out_if.source out_o
);
  import tbt_pkg::*;

  // global advance: move when the output register is empty or being drained
  logic       en;
  logic       out_v_q;
  logic [31:0] cross_x_q, cross_z_q;
  status_e    status_q;

  coord_t     coord;
  logic       sl_valid;
  slope_res_t sl_res;
  logic       nm_valid;
  num_t       nm;
  logic       dv_valid;
  quo_t       quo;

  logic [32:0] cz_sv, cx_sv;
  logic [31:0] cross_x_d, cross_z_d;
  status_e     status_d;

  assign en = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  assign coord = '{x1: in_i.first_x, z1: in_i.first_z,
                   x2: in_i.second_x, z2: in_i.second_z};

  // cordic rotation and tangent division, one lane per heading
  tbt_slope u_slope (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (en),
    .valid_i          (in_i.valid),
    .first_heading_i  (in_i.first_heading),
    .second_heading_i (in_i.second_heading),
    .coord_i          (coord),
    .valid_o          (sl_valid),
    .res_o            (sl_res)
  );

  // exact numerators, rounding offset and signs
  tbt_isect u_isect (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sl_valid),
    .res_i   (sl_res),
    .valid_o (nm_valid),
    .num_o   (nm)
  );

  // one quotient bit per stage for both coordinates
  tbt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nm_valid),
    .num_i   (nm),
    .valid_o (dv_valid),
    .quo_o   (quo)
  );

  // apply sign and clamp to the 32 bit range, {sat, value}
  function automatic logic [32:0] clamp(logic [31:0] q, logic ovf, logic neg);
    logic        sat;
    logic [31:0] v;
    sat = ovf || (neg ? (q > 32'h8000_0000) : q[31]);
    if (sat) v = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else     v = neg ? -q : q;
    return {sat, v};
  endfunction

  always_comb begin
    cz_sv = clamp(quo.qz, quo.ovfz, quo.negz);
    cx_sv = clamp(quo.qx, quo.ovfx, quo.negx);
    priority if (quo.par) begin
      // parallel bearings or coincident points: no crossing
      cross_x_d = '0;
      cross_z_d = '0;
      status_d  = ST_PARALLEL;
    end else if (cz_sv[32] || cx_sv[32]) begin
      cross_x_d = cx_sv[31:0];
      cross_z_d = cz_sv[31:0];
      status_d  = ST_SAT;
    end else begin
      cross_x_d = cx_sv[31:0];
      cross_z_d = cz_sv[31:0];
      status_d  = ST_OK;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= dv_valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cross_x_q <= cross_x_d;
      cross_z_q <= cross_z_d;
      status_q  <= status_d;
    end
  end

  assign out_o.valid   = out_v_q;
  assign out_o.cross_x = cross_x_q;
  assign out_o.cross_z = cross_z_q;
  assign out_o.status  = status_q;

endmodule

@@ rtl/tbt_checker.sv @@
`timescale 1ns / 1ps

module tbt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] cross_x_i,
  input logic [31:0] cross_z_i,
  input logic [1:0]  status_i
);
  import tbt_pkg::*;

  // a stalled result holds the input side
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |-> !in_ready_i)
    else $error("input taken while result stalled");

  a_empty_takes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input refused with empty output");

  a_parallel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (status_i == ST_PARALLEL)) |-> (cross_x_i == '0 && cross_z_i == '0))
    else $error("parallel result not zero");

  a_sat_on_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (status_i == ST_SAT)) |->
      (cross_x_i == 32'h8000_0000 || cross_x_i == 32'h7FFF_FFFF ||
       cross_z_i == 32'h8000_0000 || cross_z_i == 32'h7FFF_FFFF))
    else $error("saturated result off the rails");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(cross_x_i) && $stable(cross_z_i) && $stable(status_i)))
    else $error("stalled result beat changed");

endmodule

bind two_bearing_triangulation tbt_checker u_tbt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .cross_x_i   (out_o.cross_x),
  .cross_z_i   (out_o.cross_z),
  .status_i    (out_o.status)
);

@@ sim/tb_two_bearing_triangulation.sv @@
`timescale 1ns / 1ps

module tb_two_bearing_triangulation;
  import tbt_pkg::*;

  // generous ceiling: ~2000 beats with both sides idling fit well within it
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 150;   // pipeline latency plus margin
  localparam int PHASE_ITEMS = 490;
  localparam longint TAN_SAT = 64'sd2147483647;

  typedef struct {
    logic signed [31:0] x1;
    logic signed [31:0] z1;
    logic [15:0]        h1;
    logic signed [31:0] x2;
    logic signed [31:0] z2;
    logic [15:0]        h2;
  } bearing_pair_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] z;
    status_e            st;
  } fix_t;

  // one row of the directed table; known marks a result typed in by hand
  typedef struct {
    bearing_pair_t pair;
    bit            known;
    fix_t          fix;
  } vector_t;

  logic clk;
  logic rst_n;

  tbt_in_if  in_if ();
  tbt_out_if out_if ();

  two_bearing_triangulation dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  fix_t    pending_fixes[$];
  vector_t vectors[$];
  int      n_errors;
  int      n_sent;
  int      n_checked;
  int      n_parallel;
  int      n_saturated;
  int      idle_pct;
  int      stall_pct;
  longint  cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // slope k = -tan(heading) in Q16.16, saturated near +-90 degrees
  function automatic logic signed [31:0] bearing_slope(logic [15:0] head);
    logic [15:0] h;
    longint ang, x, y, nx, ay, s;
    h = head & HEAD_MASK;
    // fold into [-pi/2, pi/2): tan has period pi
    ang = longint'({1'b0, h[14:0], 16'b0});
    if (ang >= (longint'(1) <<< 30)) ang -= (longint'(1) <<< 31);
    x = longint'(1) <<< 30;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (ang >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        ang -= longint'(ATAN_TAB[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        ang += longint'(ATAN_TAB[i]);
      end
      x = nx;
    end
    ay = (y < 0) ? -y : y;
    if (x <= 0 || ay * 65536 >= TAN_SAT * x) s = (y < 0) ? -TAN_SAT : TAN_SAT;
    else s = (y * 65536) / x;
    return 32'(-s);
  endfunction

  // num/den rounded half away from zero, clamped to 32 bits
  function automatic logic signed [31:0] round_clamp(logic signed [127:0] num,
                                                     logic signed [127:0] den,
                                                     inout bit sat);
    logic [127:0] un, ud, q;
    bit neg;
    neg = num[127] != den[127];
    un = num[127] ? -num : num;
    ud = den[127] ? -den : den;
    q = (un + (ud >> 1)) / ud;
    if (neg ? (q > 128'h8000_0000) : (q > 128'h7FFF_FFFF)) begin
      sat = 1'b1;
      return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic fix_t cross_point(bearing_pair_t p);
    logic signed [127:0] k1, k2, x1, z1, x2, z2, d, nz, nx;
    fix_t f;
    bit sat;
    k1 = bearing_slope(p.h1);
    k2 = bearing_slope(p.h2);
    x1 = p.x1; z1 = p.z1; x2 = p.x2; z2 = p.z2;
    sat = 1'b0;
    f.x = '0;
    f.z = '0;
    f.st = ST_OK;
    if (k1 == k2 || (x1 == x2 && z1 == z2)) begin
      f.st = ST_PARALLEL;
    end else begin
      d = k1 - k2;
      nz = k1 * z1 - k2 * z2 + (x2 - x1) * 65536;
      nx = k1 * k2 * (z1 - z2) + x2 * k1 * 65536 - x1 * k2 * 65536;
      f.z = round_clamp(nz, d, sat);
      f.x = round_clamp(nx, d * 65536, sat);
      if (sat) f.st = ST_SAT;
    end
    return f;
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("mismatch at result %0d: %s expected %0d got %0d", n_checked, what, want, got);
    n_errors++;
  endtask

  task automatic add_vector(int x1, int z1, int h1, int x2, int z2, int h2,
                            bit known = 1'b0, int fx = 0, int fz = 0,
                            status_e st = ST_OK);
    vector_t v;
    v.pair = '{32'(x1), 32'(z1), 16'(h1), 32'(x2), 32'(z2), 16'(h2)};
    v.known = known;
    v.fix = '{32'(fx), 32'(fz), st};
    vectors.insert(vectors.size(), v);
  endtask

  // random pair: mostly sensible geometry, some raw noise and the corner cases
  function automatic bearing_pair_t random_pair();
    bearing_pair_t p;
    int mode;
    mode = $urandom_range(0, 9);
    p.h1 = 16'($urandom);
    p.h2 = 16'($urandom);
    if (mode <= 2) begin
      p.x1 = $urandom; p.z1 = $urandom; p.x2 = $urandom; p.z2 = $urandom;
    end else begin
      p.x1 = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      p.z1 = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      p.x2 = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      p.z2 = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
    end
    case (mode)
      6: p.h2 = p.h1;                                  // equal slopes
      7: p.h2 = p.h1 + 16'h8000;                       // opposite bearings
      8: begin p.x2 = p.x1; p.z2 = p.z1; end           // same observation point
      9: p.h1 = 16'h4000 + 16'($urandom_range(0, 6)) - 16'd3;  // near +-90 degrees
      default: ;
    endcase
    return p;
  endfunction

  // one beat: hold valid until the sink takes it, then book the expected fix
  task automatic send_pair(bearing_pair_t p, bit known, fix_t fix);
    in_if.valid          <= 1'b1;
    in_if.first_x        <= p.x1;
    in_if.first_z        <= p.z1;
    in_if.first_heading  <= p.h1;
    in_if.second_x       <= p.x2;
    in_if.second_z       <= p.z2;
    in_if.second_heading <= p.h2;
    do @(posedge clk); while (!in_if.ready);
    pending_fixes.insert(pending_fixes.size(), known ? fix : cross_point(p));
    n_sent++;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_fixes.size() != 0) @(posedge clk);
  endtask

  // result side: random back-pressure and the field-by-field check
  always @(posedge clk) begin
    fix_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_fixes.size() == 0) begin
        $display("unexpected result beat: x %0d z %0d status %0d",
                 out_if.cross_x, out_if.cross_z, out_if.status);
        n_errors++;
      end else begin
        want = pending_fixes.pop_front();
        if (out_if.cross_x !== want.x) report_mismatch("cross_x", want.x, out_if.cross_x);
        if (out_if.cross_z !== want.z) report_mismatch("cross_z", want.z, out_if.cross_z);
        if (out_if.status !== want.st) report_mismatch("status", want.st, out_if.status);
        if (want.st == ST_PARALLEL) n_parallel++;
        if (want.st == ST_SAT) n_saturated++;
        n_checked++;
      end
    end
    out_if.ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
  end

  // watchdog on total cycles
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_fixes.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    fix_t none;
    none = '{0, 0, ST_OK};
    n_sent = 0;
    idle_pct = 0; stall_pct = 0;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.first_x <= '0; in_if.first_z <= '0; in_if.first_heading <= '0;
    in_if.second_x <= '0; in_if.second_z <= '0; in_if.second_heading <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; hand-typed results only where obvious
    add_vector(0, 0, 0, 0, 0, 0, 1'b1, 0, 0, ST_PARALLEL);             // all zero
    add_vector(0, 0, 0, 160, 320, -32768, 1'b1, 0, 0, ST_PARALLEL);    // bearings pi apart
    add_vector(48, -16, 0, 48, -16, 8192, 1'b1, 0, 0, ST_PARALLEL);    // same point
    add_vector(-7, 5, 2000, -7, 5, -2000, 1'b1, 0, 0, ST_PARALLEL);    // same point, other slopes
    add_vector(0, 0, 8192, 160, 0, -8192);                             // 45 degree pair
    add_vector(0, 0, 16384, 160, 160, 0);                              // slope clamps at +90
    add_vector(16, 32, -16384, -160, 80, 8192);                        // slope clamps at -90
    add_vector(0, 0, 16383, 16, 16, 16385);                            // either side of 90
    add_vector(32'h7FFF_FFFF, 32'h8000_0000, 8192, 32'h8000_0000, 32'h7FFF_FFFF, -8192);
    add_vector(32'h8000_0000, 32'h8000_0000, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -1);
    add_vector(0, 0, 1, 32'h7FFF_FFFF, 0, 0);                          // near-parallel, clamps
    add_vector(100, -100, 32767, -100, 100, -32768);                   // heading extremes
    add_vector(-1, -1, -1, 1, 1, 32767);
    add_vector(5000, 0, 4096, -5000, 0, -4096);
    add_vector(0, 32'h7FFF_FFFF, 12000, 0, 32'h8000_0000, -20000);
    add_vector(123456, -654321, 24576, -13579, 24680, 10923);
    foreach (vectors[i]) send_pair(vectors[i].pair, vectors[i].known, vectors[i].fix);

    // hold off until the pipe is empty before the random part
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // short runs with no idling inside every phase
        if (n % 100 == 50) begin
          idle_pct = 0;
        end else if (n % 100 == 70) begin
          idle_pct = (ph == 1) ? 51 : (ph == 3) ? 34 : 0;
        end
        send_pair(random_pair(), 1'b0, none);
      end
      if (ph == 1) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d bearing pairs, checked %0d fixes over four idle/stall phases",
             n_sent, n_checked);
    $display("parallel or coincident cases %0d, clamped results %0d, mismatches %0d",
             n_parallel, n_saturated, n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
